FILE: rtl/core/mf5_pkg.sv
// Shared types, constants and the sorting network layer function for the
// 5x5 RGB median filter. Used by every module in rtl/core.
`timescale 1ns / 1ps
package mf5_pkg;

   localparam int MAX_PADDED_PX = 1024;
   localparam int WIN_SIZE      = 5;
   localparam int CHANNELS      = 3;
   localparam int HIST_ROWS     = WIN_SIZE - 1;
   localparam int LINE_BYTES    = MAX_PADDED_PX * CHANNELS;
   localparam int WIN_SPAN      = (WIN_SIZE - 1) * CHANNELS + 1;
   localparam int TAPS          = WIN_SIZE * WIN_SIZE;
   localparam int ADDR_W        = $clog2(LINE_BYTES);
   localparam int LANE_W        = $clog2(HIST_ROWS);

   // Sorting network size: next power of two above the tap count.
   localparam int SORT_N        = 32;
   localparam int SORT_LAYERS   = 15;
   localparam int LAYERS_PER_STG = 3;
   localparam int SORT_STAGES   = SORT_LAYERS / LAYERS_PER_STG;

   localparam logic [12:0] ROW_COUNT_MAX = 13'd8191;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_OUT_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_PADDED_WIDTH = 2'd1;
   localparam logic [1:0] CSR_OUT_HEIGHT   = 2'd2;

   typedef logic [7:0] pix_type;
   typedef logic [SORT_N-1:0][7:0] pix_vec_type;
   typedef logic [TAPS-1:0][7:0] tap_vec_type;
   typedef logic [HIST_ROWS-1:0][7:0] lane_vec_type;

   // Sideband that travels with a beat down the sorter.
   typedef struct packed {
      logic valid;
      logic row_last;
      logic frame_last;
   } tag_type;

   // Merge size (log2 p) and compare distance (log2 k) of each layer.
   localparam int LAYER_LP [SORT_LAYERS] = '{0, 1, 1, 2, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 4};
   localparam int LAYER_LK [SORT_LAYERS] = '{0, 1, 0, 2, 1, 0, 3, 2, 1, 0, 4, 3, 2, 1, 0};

   // One layer of the odd-even merge sort: independent compare-exchanges.
   function automatic pix_vec_type sort_layer(input pix_vec_type v, input int lp,
                                              input int lk);
      pix_vec_type r;
      int k;
      int j0;
      int d;
      r  = v;
      k  = 1 << lk;
      j0 = (lk == lp) ? 0 : k;
      for (int x = 0; x < SORT_N; x++) begin
         d = x - j0;
         if (x >= j0 && x + k < SORT_N && (d & (2 * k - 1)) < k &&
             (x >> (lp + 1)) == ((x + k) >> (lp + 1))) begin
            if (v[x] > v[x + k]) begin
               r[x]     = v[x + k];
               r[x + k] = v[x];
            end
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/mf5_line_ram.sv
// Four line buffers, one lane per buffered source row, read-first per lane.
// Depends on mf5_pkg.
`timescale 1ns / 1ps
module mf5_line_ram (
   input  logic                        clock,
   input  logic                        en,
   input  logic [mf5_pkg::ADDR_W-1:0]  addr,
   input  logic [mf5_pkg::LANE_W-1:0]  wr_lane,
   input  mf5_pkg::pix_type            wdata,
   output mf5_pkg::lane_vec_type       rdata
);
   import mf5_pkg::*;

   pix_type      mem [HIST_ROWS][LINE_BYTES];
   lane_vec_type rd_ff;

   // All lanes read the same column; only the current row's lane is written.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < HIST_ROWS; l++) begin
            rd_ff[l] <= mem[l][addr];
            if (wr_lane == LANE_W'(l)) begin
               mem[l][addr] <= wdata;
            end
         end
      end
   end

   assign rdata = rd_ff;
endmodule

FILE: rtl/core/mf5_win_row.sv
// One row cell of the window: a 13-byte shift line with same-channel taps.
// Depends on mf5_pkg.
`timescale 1ns / 1ps
module mf5_win_row (
   input  logic                                  clock,
   input  logic                                  shift,
   input  mf5_pkg::pix_type                      din,
   output logic [mf5_pkg::WIN_SIZE-1:0][7:0]     taps
);
   import mf5_pkg::*;

   logic [WIN_SPAN-1:0][7:0] line_ff;

   // Oldest byte at index 0, newest enters at the top.
   always_ff @(posedge clock) begin
      if (shift) begin
         line_ff <= {din, line_ff[WIN_SPAN-1:1]};
      end
   end

   // Every third byte belongs to the same color channel.
   always_comb begin
      for (int t = 0; t < WIN_SIZE; t++) begin
         taps[t] = line_ff[t * CHANNELS];
      end
   end
endmodule

FILE: rtl/core/mf5_sort_net.sv
// Pipelined odd-even merge sorting network, three layers per stage.
// Depends on mf5_pkg.
`timescale 1ns / 1ps
module mf5_sort_net (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  mf5_pkg::tag_type     in_tag,
   input  mf5_pkg::tap_vec_type taps,
   output mf5_pkg::tag_type     out_tag,
   output mf5_pkg::pix_type     median
);
   import mf5_pkg::*;

   pix_vec_type vec_ff [SORT_STAGES];
   tag_type     tag_ff [SORT_STAGES];
   pix_vec_type vec_in [SORT_STAGES];
   pix_vec_type src    [SORT_STAGES];

   // Unused network inputs sit at the maximum so they sort to the top.
   always_comb begin
      src[0] = '1;
      for (int i = 0; i < TAPS; i++) begin
         src[0][i] = taps[i];
      end
      for (int g = 1; g < SORT_STAGES; g++) begin
         src[g] = vec_ff[g-1];
      end
   end

   // Each stage applies its share of the layers to the previous register.
   always_comb begin
      for (int g = 0; g < SORT_STAGES; g++) begin
         vec_in[g] = src[g];
         for (int l = 0; l < LAYERS_PER_STG; l++) begin
            vec_in[g] = sort_layer(vec_in[g], LAYER_LP[g * LAYERS_PER_STG + l],
                                   LAYER_LK[g * LAYERS_PER_STG + l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int g = 0; g < SORT_STAGES; g++) begin
            vec_ff[g] <= vec_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < SORT_STAGES; g++) begin
            tag_ff[g] <= '0;
         end
      end else if (adv) begin
         tag_ff[0] <= in_tag;
         for (int g = 1; g < SORT_STAGES; g++) begin
            tag_ff[g] <= tag_ff[g-1];
         end
      end
   end

   assign out_tag = tag_ff[SORT_STAGES-1];
   assign median  = vec_ff[SORT_STAGES-1][TAPS/2];
endmodule

FILE: rtl/core/median_filter_5x5_rgb_top.sv
// 5x5 per-channel median filter over a padded interleaved RGB byte stream.
// A beat's result is registered through the line buffer read, the window rows
// and the sorter stages. Throughput: one byte per cycle; the whole pipeline
// holds only while a presented result is not taken. Synchronous active-high
// reset clears the counters and valid flags and loads 640, 644 and 480 into the
// registers; line and window contents are undefined until written.
`timescale 1ns / 1ps
module median_filter_5x5_rgb_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_median,
   output logic        rsp_row_last,
   output logic        rsp_frame_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import mf5_pkg::*;

   logic [9:0]  out_width_ff;
   logic [10:0] padded_width_ff;
   logic [11:0] out_height_ff;
   logic [12:0] row_ff, row_in;
   logic [11:0] byte_ff, byte_in;

   logic        adv, acc;
   logic [10:0] pw, ow;
   logic [11:0] oh, lb, row_bytes;
   logic [12:0] rr, rr_base, rr_sat;
   logic [11:0] b, b_base, b_next, c;
   logic [12:0] r;
   logic        prod, rl, fl;

   logic                v1_ff;
   tag_type             tag1_ff;
   logic [LANE_W-1:0]   lane1_ff;
   pix_type             smp1_ff;
   tag_type             tag2_ff;
   lane_vec_type        lane_rd;
   tap_vec_type         taps;
   logic [WIN_SIZE-1:0][WIN_SIZE-1:0][7:0] row_taps;
   tag_type             out_tag;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff    <= 10'd640;
         padded_width_ff <= 11'd644;
         out_height_ff   <= 12'd480;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OUT_WIDTH:    out_width_ff    <= csr_wdata[9:0];
            CSR_PADDED_WIDTH: padded_width_ff <= csr_wdata[10:0];
            CSR_OUT_HEIGHT:   out_height_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves unless a result is waiting.
   assign adv       = !out_tag.valid || rsp_ready;
   assign req_ready = adv;
   assign acc       = req_valid && adv;

   // Clamp the geometry registers.
   always_comb begin
      if (padded_width_ff < 11'(WIN_SIZE))           pw = 11'(WIN_SIZE);
      else if (padded_width_ff > 11'(MAX_PADDED_PX)) pw = 11'(MAX_PADDED_PX);
      else                                           pw = padded_width_ff;
      ow = (out_width_ff == 10'd0) ? 11'd1 : {1'b0, out_width_ff};
      if (ow > pw - 11'(HIST_ROWS)) ow = pw - 11'(HIST_ROWS);
      oh        = (out_height_ff == 12'd0) ? 12'd1 : out_height_ff;
      lb        = {pw, 1'b0} + {1'b0, pw};
      row_bytes = {ow, 1'b0} + {1'b0, ow};
   end

   // Source position of the incoming beat and whether it completes a window.
   always_comb begin
      rr_base = req_frame_start ? 13'd0 : row_ff;
      b_base  = req_frame_start ? 12'd0 : byte_ff;
      rr_sat  = (rr_base < ROW_COUNT_MAX) ? rr_base + 13'd1 : rr_base;
      if (b_base >= lb) begin
         b  = 12'd0;
         rr = rr_sat;
      end else begin
         b  = b_base;
         rr = rr_base;
      end
      b_next = b + 12'd1;
      if (b_next >= lb) begin
         byte_in = 12'd0;
         row_in  = (rr < ROW_COUNT_MAX) ? rr + 13'd1 : rr;
      end else begin
         byte_in = b_next;
         row_in  = rr;
      end
      r    = rr - 13'(HIST_ROWS);
      c    = b - 12'(WIN_SPAN - 1);
      prod = (rr >= 13'(HIST_ROWS)) && (b >= 12'(WIN_SPAN - 1)) &&
             (r < {1'b0, oh}) && (c < row_bytes);
      rl   = (c == row_bytes - 12'd1);
      fl   = rl && (r == {1'b0, oh - 12'd1});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         byte_ff <= '0;
      end else if (acc) begin
         row_ff  <= row_in;
         byte_ff <= byte_in;
      end
   end

   // Line buffers, read at the column of the beat and written in its row lane.
   mf5_line_ram u_line_ram (
      .clock   (clock),
      .en      (acc),
      .addr    (b),
      .wr_lane (rr[LANE_W-1:0]),
      .wdata   (req_sample),
      .rdata   (lane_rd)
   );

   // Stage one: line buffer data arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         tag1_ff  <= '{valid: prod, row_last: rl, frame_last: fl};
         lane1_ff <= rr[LANE_W-1:0];
         smp1_ff  <= req_sample;
      end
   end

   // Stage two: the window rows shift in their new column.
   for (genvar k = 0; k < WIN_SIZE; k++) begin : g_row
      pix_type           din;
      logic [LANE_W-1:0] sel;
      assign sel = lane1_ff + LANE_W'(k);
      if (k < HIST_ROWS) begin : g_hist
         assign din = lane_rd[sel];
      end else begin : g_new
         assign din = smp1_ff;
      end
      mf5_win_row u_row (
         .clock (clock),
         .shift (adv && v1_ff),
         .din   (din),
         .taps  (row_taps[k])
      );
   end

   always_comb begin
      for (int k = 0; k < WIN_SIZE; k++) begin
         for (int t = 0; t < WIN_SIZE; t++) begin
            taps[k * WIN_SIZE + t] = row_taps[k][t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
      end else if (adv) begin
         tag2_ff <= v1_ff ? tag1_ff : '0;
      end
   end

   // Sorting network; its last stage is the result register.
   mf5_sort_net u_sort (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tag  (tag2_ff),
      .taps    (taps),
      .out_tag (out_tag),
      .median  (rsp_median)
   );

   assign rsp_valid      = out_tag.valid;
   assign rsp_row_last   = out_tag.row_last;
   assign rsp_frame_last = out_tag.frame_last;
endmodule
